[src/pds_pkg.sv]
// Shared types, codes and constants of the priority dispatch scheduler.
package pds_pkg;

    // Default sizing of the pending table and of the stored priority.
    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_PRIORITY_BITS = 16;

    // Fixed field widths.
    localparam int REQ_W     = 3;
    localparam int HANDLE_W  = 16;
    localparam int PRIO_IN_W = 16;
    localparam int AGE_W     = 32;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int STATUS_W  = 2;
    localparam int ACTIVE_W  = 4;
    localparam int QCOUNT_W  = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONCURRENT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_THREADS = 1'd1;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RST_MAX_CONCURRENT = 4'd0;
    localparam logic [CFG_W-1:0] RST_WORKER_THREADS = 4'd2;

    // First handle handed out after reset and after a wrap.
    localparam logic [HANDLE_W-1:0] FIRST_HANDLE = 16'd1;
    localparam logic [HANDLE_W-1:0] LAST_HANDLE  = 16'hFFFF;

    // Request types; codes five to seven carry no meaning.
    typedef enum logic [REQ_W-1:0] {
        REQ_SUBMIT   = 3'd0,
        REQ_COMPLETE = 3'd1,
        REQ_CANCEL   = 3'd2,
        REQ_SET_PRIO = 3'd3,
        REQ_FLUSH    = 3'd4
    } t_req;

    // Acknowledge status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_NOT_QUEUED = 2'd2
    } t_status;

    // Result kinds.
    typedef enum logic {
        KIND_DISPATCH = 1'b0,
        KIND_ACK      = 1'b1
    } t_kind;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_APPLY,
        S_CHECK,
        S_BEST,
        S_DISPATCH,
        S_ACK
    } t_state;

    // Control of one table scan.
    typedef struct packed {
        logic clear;
        logic en;
    } t_scan_ctl;

    // What a finished scan found.
    typedef struct packed {
        logic free_found;
        logic hit_found;
        logic best_found;
    } t_scan_flags;

endpackage

[src/priority_dispatch_scheduler.sv]
// Priority dispatch scheduler: sequencer, table state and result register.
//
// Each accepted item is an event (submit, complete, cancel, set priority, flush) that is
// applied to a pending table, after which the block dispatches the best queued entries
// while the in-flight count is below the budget, one dispatch result each, and closes with
// one acknowledge result marked last. All table searches run through a single compare unit
// that reads one entry per cycle from the table memory. Submit, cancel and set priority
// need one scan to locate their slot; every dispatch needs one more scan for the winner.
// The input is stalled from the acceptance of an item until its acknowledge result is
// loaded, and each dispatch or acknowledge result waits while the output is stalled.
// The user must write configuration only while the block is idle; the block itself
// does not enforce this.
module priority_dispatch_scheduler #(
    parameter int QUEUE_DEPTH   = pds_pkg::DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = pds_pkg::DEF_PRIORITY_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port.
    input  logic                                i_cfg_wr_en,
    input  logic [pds_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pds_pkg::CFG_W-1:0]           i_cfg_data,
    // Event channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [pds_pkg::REQ_W-1:0]           i_req_type,
    input  logic [pds_pkg::HANDLE_W-1:0]        i_handle,
    input  logic signed [pds_pkg::PRIO_IN_W-1:0] i_priority_req,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_result_kind,
    output logic [pds_pkg::HANDLE_W-1:0]        o_result_handle,
    output logic [pds_pkg::STATUS_W-1:0]        o_status,
    output logic [pds_pkg::ACTIVE_W-1:0]        o_in_flight_count,
    output logic [pds_pkg::QCOUNT_W-1:0]        o_queued_count,
    output logic                                o_last
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    // Sequencer and event registers.
    pds_pkg::t_state                  r_state, n_state;
    pds_pkg::t_req                    r_req_type, n_req_type;
    logic [pds_pkg::HANDLE_W-1:0]     r_handle, n_handle;
    logic signed [PRIORITY_BITS-1:0]  r_prio, n_prio;
    logic [CNT_W-1:0]                 r_scan_cnt, n_scan_cnt;

    // Table bookkeeping.
    logic [QUEUE_DEPTH-1:0]           r_valid, n_valid;
    logic [CNT_W-1:0]                 r_queued, n_queued;
    logic [pds_pkg::ACTIVE_W-1:0]     r_active, n_active;
    logic [pds_pkg::AGE_W-1:0]        r_next_age, n_next_age;
    logic [pds_pkg::HANDLE_W-1:0]     r_next_handle, n_next_handle;

    // Acknowledge contents.
    logic [pds_pkg::HANDLE_W-1:0]     r_ack_handle, n_ack_handle;
    pds_pkg::t_status                 r_ack_status, n_ack_status;

    // Configuration registers.
    logic [pds_pkg::CFG_W-1:0]        r_max_conc;
    logic [pds_pkg::CFG_W-1:0]        r_workers;

    // Result register.
    logic                             r_out_valid, n_out_valid;
    pds_pkg::t_kind                   r_out_kind, n_out_kind;
    logic [pds_pkg::HANDLE_W-1:0]     r_out_handle, n_out_handle;
    pds_pkg::t_status                 r_out_status, n_out_status;
    logic [pds_pkg::ACTIVE_W-1:0]     r_out_active, n_out_active;
    logic [CNT_W-1:0]                 r_out_queued, n_out_queued;
    logic                             r_out_last, n_out_last;

    // Datapath wiring.
    logic                             w_in_accept;
    logic                             w_out_free;
    logic                             w_scanning;
    logic [CNT_W-1:0]                 w_cnt_m1;
    logic [IDX_W-1:0]                 w_data_idx;
    logic [pds_pkg::CFG_W-1:0]        w_budget;
    pds_pkg::t_scan_ctl               w_scan_ctl;
    pds_pkg::t_scan_flags             w_flags;
    logic [IDX_W-1:0]                 w_free_idx;
    logic [IDX_W-1:0]                 w_hit_idx;
    logic [IDX_W-1:0]                 w_best_idx;
    logic [pds_pkg::HANDLE_W-1:0]     w_best_handle;
    logic [pds_pkg::HANDLE_W-1:0]     w_rd_handle;
    logic signed [PRIORITY_BITS-1:0]  w_rd_prio;
    logic [pds_pkg::AGE_W-1:0]        w_rd_age;
    logic                             w_wr_entry;
    logic                             w_wr_prio;
    logic [IDX_W-1:0]                 w_wr_addr;

    // Handshake helpers.
    assign o_in_stall  = (r_state != pds_pkg::S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // A scan issues one read per cycle; the data of the previous address is compared.
    assign w_scanning = (r_state == pds_pkg::S_FIND) || (r_state == pds_pkg::S_BEST);
    assign w_cnt_m1   = r_scan_cnt - CNT_W'(1);
    assign w_data_idx = w_cnt_m1[IDX_W-1:0];
    assign w_scan_ctl.clear = w_scanning && (r_scan_cnt == '0);
    assign w_scan_ctl.en    = w_scanning && (r_scan_cnt != '0);

    // Zero max_concurrent falls back to the worker count, and a zero worker count to one.
    assign w_budget = (r_max_conc != '0) ? r_max_conc :
                      ((r_workers != '0) ? r_workers : pds_pkg::CFG_W'(1));

    // Table memory writes happen only while applying an event.
    assign w_wr_entry = (r_state == pds_pkg::S_APPLY) && (r_req_type == pds_pkg::REQ_SUBMIT) &&
                        w_flags.free_found;
    assign w_wr_prio  = (r_state == pds_pkg::S_APPLY) &&
                        (r_req_type == pds_pkg::REQ_SET_PRIO) && w_flags.hit_found;
    assign w_wr_addr  = (r_req_type == pds_pkg::REQ_SUBMIT) ? w_free_idx : w_hit_idx;

    pds_entry_store #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_store (
        .i_clk         (i_clk),
        .i_rd_en       (w_scanning && (r_scan_cnt < DEPTH_CNT)),
        .i_rd_addr     (r_scan_cnt[IDX_W-1:0]),
        .i_wr_entry    (w_wr_entry),
        .i_wr_prio     (w_wr_prio),
        .i_wr_addr     (w_wr_addr),
        .i_wr_handle   (r_next_handle),
        .i_wr_prio_val (r_prio),
        .i_wr_age      (r_next_age),
        .o_rd_handle   (w_rd_handle),
        .o_rd_prio     (w_rd_prio),
        .o_rd_age      (w_rd_age)
    );

    pds_scan_unit #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_scan_ctl),
        .i_idx         (w_data_idx),
        .i_cand_valid  (r_valid[w_data_idx]),
        .i_cand_handle (w_rd_handle),
        .i_cand_prio   (w_rd_prio),
        .i_cand_age    (w_rd_age),
        .i_next_age    (r_next_age),
        .i_target      (r_handle),
        .o_flags       (w_flags),
        .o_free_idx    (w_free_idx),
        .o_hit_idx     (w_hit_idx),
        .o_best_idx    (w_best_idx),
        .o_best_handle (w_best_handle)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_conc <= pds_pkg::RST_MAX_CONCURRENT;
            r_workers  <= pds_pkg::RST_WORKER_THREADS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pds_pkg::CFG_MAX_CONCURRENT: r_max_conc <= i_cfg_data;
                pds_pkg::CFG_WORKER_THREADS: r_workers  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: next state, table updates and result loading.
    always_comb begin
        n_state       = r_state;
        n_req_type    = r_req_type;
        n_handle      = r_handle;
        n_prio        = r_prio;
        n_scan_cnt    = r_scan_cnt;
        n_valid       = r_valid;
        n_queued      = r_queued;
        n_active      = r_active;
        n_next_age    = r_next_age;
        n_next_handle = r_next_handle;
        n_ack_handle  = r_ack_handle;
        n_ack_status  = r_ack_status;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_kind    = r_out_kind;
        n_out_handle  = r_out_handle;
        n_out_status  = r_out_status;
        n_out_active  = r_out_active;
        n_out_queued  = r_out_queued;
        n_out_last    = r_out_last;

        case (r_state)
            // Take an event; only submit, cancel and set priority need a table search.
            pds_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    n_req_type = pds_pkg::t_req'(i_req_type);
                    n_handle   = i_handle;
                    n_prio     = PRIORITY_BITS'(i_priority_req);
                    n_scan_cnt = '0;
                    if ((i_req_type == pds_pkg::REQ_SUBMIT) ||
                        (i_req_type == pds_pkg::REQ_CANCEL) ||
                        (i_req_type == pds_pkg::REQ_SET_PRIO)) begin
                        n_state = pds_pkg::S_FIND;
                    end else begin
                        n_state = pds_pkg::S_APPLY;
                    end
                end
            end

            // Table scans step the address counter until the last entry is compared.
            pds_pkg::S_FIND: begin
                n_scan_cnt = r_scan_cnt + CNT_W'(1);
                if (r_scan_cnt == DEPTH_CNT) begin
                    n_state = pds_pkg::S_APPLY;
                end
            end

            // Apply the event to the table and fix the acknowledge contents.
            pds_pkg::S_APPLY: begin
                n_ack_handle = r_handle;
                n_ack_status = pds_pkg::STAT_OK;
                n_state      = pds_pkg::S_CHECK;
                case (r_req_type)
                    pds_pkg::REQ_SUBMIT: begin
                        if (w_flags.free_found) begin
                            n_valid[w_free_idx] = 1'b1;
                            n_queued      = r_queued + CNT_W'(1);
                            n_ack_handle  = r_next_handle;
                            n_next_age    = r_next_age + pds_pkg::AGE_W'(1);
                            n_next_handle = (r_next_handle == pds_pkg::LAST_HANDLE) ?
                                            pds_pkg::FIRST_HANDLE :
                                            r_next_handle + pds_pkg::HANDLE_W'(1);
                        end else begin
                            n_ack_handle = '0;
                            n_ack_status = pds_pkg::STAT_FULL;
                        end
                    end
                    pds_pkg::REQ_COMPLETE: begin
                        if (r_active != '0) begin
                            n_active = r_active - pds_pkg::ACTIVE_W'(1);
                        end
                    end
                    pds_pkg::REQ_CANCEL: begin
                        if (w_flags.hit_found) begin
                            n_valid[w_hit_idx] = 1'b0;
                            n_queued = r_queued - CNT_W'(1);
                        end else begin
                            n_ack_status = pds_pkg::STAT_NOT_QUEUED;
                        end
                    end
                    pds_pkg::REQ_SET_PRIO: begin
                        if (!w_flags.hit_found) begin
                            n_ack_status = pds_pkg::STAT_NOT_QUEUED;
                        end
                    end
                    pds_pkg::REQ_FLUSH: begin
                        n_valid      = '0;
                        n_queued     = '0;
                        n_active     = '0;
                        n_ack_handle = '0;
                    end
                    default: begin
                        n_ack_handle = '0;
                    end
                endcase
            end

            // Dispatch again while budget is left and something is queued.
            pds_pkg::S_CHECK: begin
                n_scan_cnt = '0;
                if ((r_active < w_budget) && (r_queued != '0)) begin
                    n_state = pds_pkg::S_BEST;
                end else begin
                    n_state = pds_pkg::S_ACK;
                end
            end

            pds_pkg::S_BEST: begin
                n_scan_cnt = r_scan_cnt + CNT_W'(1);
                if (r_scan_cnt == DEPTH_CNT) begin
                    n_state = pds_pkg::S_DISPATCH;
                end
            end

            // Retire the winner and emit its dispatch result.
            pds_pkg::S_DISPATCH: begin
                if (w_out_free) begin
                    n_valid[w_best_idx] = 1'b0;
                    n_queued     = r_queued - CNT_W'(1);
                    n_active     = r_active + pds_pkg::ACTIVE_W'(1);
                    n_out_valid  = 1'b1;
                    n_out_kind   = pds_pkg::KIND_DISPATCH;
                    n_out_handle = w_best_handle;
                    n_out_status = pds_pkg::STAT_OK;
                    n_out_active = r_active + pds_pkg::ACTIVE_W'(1);
                    n_out_queued = r_queued - CNT_W'(1);
                    n_out_last   = 1'b0;
                    n_state      = pds_pkg::S_CHECK;
                end
            end

            // Close the event with its acknowledge.
            pds_pkg::S_ACK: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = pds_pkg::KIND_ACK;
                    n_out_handle = r_ack_handle;
                    n_out_status = r_ack_status;
                    n_out_active = r_active;
                    n_out_queued = r_queued;
                    n_out_last   = 1'b1;
                    n_state      = pds_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = pds_pkg::S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= pds_pkg::S_IDLE;
            r_valid       <= '0;
            r_queued      <= '0;
            r_active      <= '0;
            r_next_age    <= '0;
            r_next_handle <= pds_pkg::FIRST_HANDLE;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_valid       <= n_valid;
            r_queued      <= n_queued;
            r_active      <= n_active;
            r_next_age    <= n_next_age;
            r_next_handle <= n_next_handle;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req_type   <= n_req_type;
        r_handle     <= n_handle;
        r_prio       <= n_prio;
        r_scan_cnt   <= n_scan_cnt;
        r_ack_handle <= n_ack_handle;
        r_ack_status <= n_ack_status;
        r_out_kind   <= n_out_kind;
        r_out_handle <= n_out_handle;
        r_out_status <= n_out_status;
        r_out_active <= n_out_active;
        r_out_queued <= n_out_queued;
        r_out_last   <= n_out_last;
    end

    // Result ports.
    assign o_out_valid       = r_out_valid;
    assign o_result_kind     = r_out_kind;
    assign o_result_handle   = r_out_handle;
    assign o_status          = r_out_status;
    assign o_in_flight_count = r_out_active;
    assign o_queued_count    = pds_pkg::QCOUNT_W'(r_out_queued);
    assign o_last            = r_out_last;

    // The queued count tracks the valid bits exactly.
    a_queued_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_queued == CNT_W'($countones(r_valid)))
        else $error("queued count differs from the number of valid entries");

    // The table never holds more entries than it has slots.
    a_queued_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_queued <= DEPTH_CNT)
        else $error("queued count exceeds the table depth");

    // A dispatch always has a winner, since dispatching starts only with entries queued.
    a_dispatch_has_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pds_pkg::S_DISPATCH |-> w_flags.best_found)
        else $error("dispatch without a queued winner");

    // A dispatch raises the in-flight count by exactly one.
    a_dispatch_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pds_pkg::S_DISPATCH) && w_out_free |=>
            r_active == $past(r_active) + pds_pkg::ACTIVE_W'(1))
        else $error("in-flight count did not advance on dispatch");

endmodule

[src/pds_entry_store.sv]
// Pending table storage: handle, priority and age memories with a registered read.
module pds_entry_store #(
    parameter int QUEUE_DEPTH   = pds_pkg::DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = pds_pkg::DEF_PRIORITY_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rd_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]    i_rd_addr,
    input  logic                              i_wr_entry,
    input  logic                              i_wr_prio,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]    i_wr_addr,
    input  logic [pds_pkg::HANDLE_W-1:0]      i_wr_handle,
    input  logic signed [PRIORITY_BITS-1:0]   i_wr_prio_val,
    input  logic [pds_pkg::AGE_W-1:0]         i_wr_age,
    output logic [pds_pkg::HANDLE_W-1:0]      o_rd_handle,
    output logic signed [PRIORITY_BITS-1:0]   o_rd_prio,
    output logic [pds_pkg::AGE_W-1:0]         o_rd_age
);

    logic [pds_pkg::HANDLE_W-1:0]    r_mem_handle [QUEUE_DEPTH];
    logic signed [PRIORITY_BITS-1:0] r_mem_prio   [QUEUE_DEPTH];
    logic [pds_pkg::AGE_W-1:0]       r_mem_age    [QUEUE_DEPTH];

    // Write port: a submit fills a whole entry, a priority change rewrites one field.
    always_ff @(posedge i_clk) begin
        if (i_wr_entry) begin
            r_mem_handle[i_wr_addr] <= i_wr_handle;
            r_mem_age[i_wr_addr]    <= i_wr_age;
        end
        if (i_wr_entry || i_wr_prio) begin
            r_mem_prio[i_wr_addr] <= i_wr_prio_val;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_handle <= r_mem_handle[i_rd_addr];
            o_rd_prio   <= r_mem_prio[i_rd_addr];
            o_rd_age    <= r_mem_age[i_rd_addr];
        end
    end

endmodule

[src/pds_scan_unit.sv]
// Shared compare unit that walks the table one entry a cycle and keeps the running winners.
module pds_scan_unit #(
    parameter int QUEUE_DEPTH   = pds_pkg::DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = pds_pkg::DEF_PRIORITY_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pds_pkg::t_scan_ctl                i_ctl,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]    i_idx,
    input  logic                              i_cand_valid,
    input  logic [pds_pkg::HANDLE_W-1:0]      i_cand_handle,
    input  logic signed [PRIORITY_BITS-1:0]   i_cand_prio,
    input  logic [pds_pkg::AGE_W-1:0]         i_cand_age,
    input  logic [pds_pkg::AGE_W-1:0]         i_next_age,
    input  logic [pds_pkg::HANDLE_W-1:0]      i_target,
    output pds_pkg::t_scan_flags              o_flags,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    o_free_idx,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    o_hit_idx,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    o_best_idx,
    output logic [pds_pkg::HANDLE_W-1:0]      o_best_handle
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    pds_pkg::t_scan_flags            r_flags;
    logic [IDX_W-1:0]                r_free_idx;
    logic [IDX_W-1:0]                r_hit_idx;
    logic [IDX_W-1:0]                r_best_idx;
    logic [pds_pkg::HANDLE_W-1:0]    r_best_handle;
    logic signed [PRIORITY_BITS-1:0] r_best_prio;
    logic [pds_pkg::AGE_W-1:0]       r_best_dist;

    logic [pds_pkg::AGE_W-1:0] w_dist;
    logic                      w_take_free;
    logic                      w_take_hit;
    logic                      w_take_best;

    // The oldest entry has the greatest distance behind the next age stamp.
    assign w_dist = i_next_age - i_cand_age;

    // Lowest free slot, lowest slot holding the target handle, best queued entry.
    assign w_take_free = !i_cand_valid && !r_flags.free_found;
    assign w_take_hit  = i_cand_valid && (i_cand_handle == i_target) && !r_flags.hit_found;
    assign w_take_best = i_cand_valid &&
                         (!r_flags.best_found || (i_cand_prio > r_best_prio) ||
                          ((i_cand_prio == r_best_prio) && (w_dist > r_best_dist)));

    // Found flags restart at the head of every scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_ctl.clear) begin
            r_flags <= '0;
        end else if (i_ctl.en) begin
            if (w_take_free) begin
                r_flags.free_found <= 1'b1;
            end
            if (w_take_hit) begin
                r_flags.hit_found <= 1'b1;
            end
            if (w_take_best) begin
                r_flags.best_found <= 1'b1;
            end
        end
    end

    // Winner payload follows the flags.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en && !i_ctl.clear) begin
            if (w_take_free) begin
                r_free_idx <= i_idx;
            end
            if (w_take_hit) begin
                r_hit_idx <= i_idx;
            end
            if (w_take_best) begin
                r_best_idx    <= i_idx;
                r_best_handle <= i_cand_handle;
                r_best_prio   <= i_cand_prio;
                r_best_dist   <= w_dist;
            end
        end
    end

    assign o_flags       = r_flags;
    assign o_free_idx    = r_free_idx;
    assign o_hit_idx     = r_hit_idx;
    assign o_best_idx    = r_best_idx;
    assign o_best_handle = r_best_handle;

endmodule
